FILE: rtl/lds_pkg.sv
// lds_pkg: shared constants, codes and control types of the look disk scheduler
// used by the channel interfaces, the controller and the datapath
`default_nettype none

package lds_pkg;

    localparam int MAX_CYLINDERS = 1024;
    localparam int CYL_W         = $clog2(MAX_CYLINDERS);
    localparam int ROW_BITS      = 16;
    localparam int BIT_W         = $clog2(ROW_BITS);
    localparam int ROWS          = MAX_CYLINDERS / ROW_BITS;
    localparam int ROW_W         = CYL_W - BIT_W;

    localparam int KIND_W     = 2;
    localparam int STATUS_W   = 2;
    localparam int NUMCYL_W   = 11;
    localparam int RATE_W     = 8;
    localparam int SUM_W      = 16;
    localparam int SEEK_W     = 24;
    localparam int COUNT_W    = CYL_W + 1;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 11;

    localparam logic [NUMCYL_W-1:0]  NUM_CYL_RESET   = NUMCYL_W'(1024);
    localparam logic [RATE_W-1:0]    SEEK_RATE_RESET = RATE_W'(5);
    localparam logic [SUM_W-1:0]     SUM_MAX         = '1;
    localparam logic [CFG_IDX_W-1:0] CFG_NUM_CYL     = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_SEEK_RATE   = CFG_IDX_W'(1);

    typedef enum logic [KIND_W-1:0] {
        KIND_ADD   = 2'd0,
        KIND_START = 2'd1,
        KIND_SERVE = 2'd2
    } kind_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_ACCEPTED = 2'd0,
        ST_SERVED   = 2'd1,
        ST_EMPTY    = 2'd2,
        ST_RANGE    = 2'd3
    } status_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_ADD_RD,
        S_ADD_WR,
        S_START,
        S_SERVE,
        S_LO_WAIT,
        S_HI_WAIT,
        S_DIR,
        S_MAIN_GO,
        S_MAIN_WAIT,
        S_REV_WAIT,
        S_COMMIT,
        S_RESULT
    } state_t;

    typedef enum logic [2:0] {
        DP_IDLE,
        DP_ADD,
        DP_START,
        DP_EMPTY,
        DP_DIR,
        DP_FLIP,
        DP_COMMIT
    } dp_op_t;

    typedef enum logic [1:0] {
        SCAN_LO,
        SCAN_HI,
        SCAN_MAIN,
        SCAN_REV
    } scan_sel_t;

    typedef struct packed {
        dp_op_t    op;
        logic      latch;
        logic      scan_start;
        scan_sel_t scan_sel;
        logic      capture_lo;
        logic      out_load;
    } lds_cmd_t;

    typedef struct packed {
        logic count_zero;
        logic dir_chosen;
        logic scan_done;
        logic scan_found;
    } lds_stat_t;

endpackage

`default_nettype wire

FILE: rtl/lds_if.sv
// lds_in_if and lds_out_if: valid/ready channels for request and result items
// depends on lds_pkg for field widths
`default_nettype none

interface lds_in_if
    import lds_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [KIND_W-1:0] kind;
    logic [CYL_W-1:0]  request_cylinder;
    logic [CYL_W-1:0]  head_position;

    modport source (output valid, output kind, output request_cylinder,
                    output head_position, input ready);
    modport sink   (input valid, input kind, input request_cylinder,
                    input head_position, output ready);
endinterface

interface lds_out_if
    import lds_pkg::*;
();
    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [CYL_W-1:0]    served_cylinder;
    logic [CYL_W-1:0]    step_movement;
    logic [SUM_W-1:0]    total_movement;
    logic [SEEK_W-1:0]   seek_time;
    logic                last;

    modport source (output valid, output status, output served_cylinder,
                    output step_movement, output total_movement, output seek_time,
                    output last, input ready);
    modport sink   (input valid, input status, input served_cylinder,
                    input step_movement, input total_movement, input seek_time,
                    input last, output ready);
endinterface

`default_nettype wire

FILE: rtl/lds_datapath.sv
// lds_datapath: pending bitmap memory, row scan engine, head and total registers,
// configuration registers and the result register; depends on lds_pkg
`default_nettype none

module lds_datapath
    import lds_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire lds_cmd_t              cmd,
    output lds_stat_t                  stat,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    input  wire logic [CYL_W-1:0]      request_cylinder,
    input  wire logic [CYL_W-1:0]      head_position,
    output logic [STATUS_W-1:0]        status,
    output logic [CYL_W-1:0]           served_cylinder,
    output logic [CYL_W-1:0]           step_movement,
    output logic [SUM_W-1:0]           total_movement,
    output logic [SEEK_W-1:0]          seek_time,
    output logic                       last
);

    logic [NUMCYL_W-1:0] num_cyl_reg;
    logic [RATE_W-1:0]   seek_rate_reg;

    logic [CYL_W-1:0]    req_reg;
    logic [CYL_W-1:0]    hpos_reg;

    logic [ROW_BITS-1:0] mem [ROWS];
    logic [ROWS-1:0]     row_valid_reg;
    logic [ROW_BITS-1:0] rd_data_reg;
    logic                rd_rv_reg;
    logic [ROW_W-1:0]    rd_row_reg;

    logic [COUNT_W-1:0]  count_reg;
    logic [CYL_W-1:0]    head_reg;
    logic                sweep_down_reg;
    logic                dir_chosen_reg;
    logic [SUM_W-1:0]    sum_reg;

    logic                scan_busy_reg;
    logic                scan_issue_reg;
    logic                scan_vld_reg;
    logic                scan_down_reg;
    logic                scan_incl_reg;
    logic [CYL_W-1:0]    scan_pos_reg;
    logic [ROW_W-1:0]    scan_addr_reg;

    logic [CYL_W-1:0]    target_reg;
    logic [ROW_BITS-1:0] target_word_reg;
    logic [CYL_W-1:0]    lo_reg;

    logic [STATUS_W-1:0] res_status_reg;
    logic [CYL_W-1:0]    res_served_reg;
    logic [CYL_W-1:0]    res_step_reg;
    logic                res_last_reg;
    logic                res_serve_reg;

    logic [STATUS_W-1:0] out_status_reg;
    logic [CYL_W-1:0]    out_served_reg;
    logic [CYL_W-1:0]    out_step_reg;
    logic [SUM_W-1:0]    out_total_reg;
    logic [SEEK_W-1:0]   out_seek_reg;
    logic                out_last_reg;

    logic [ROW_BITS-1:0] rd_word;
    logic [ROW_W-1:0]    raddr;
    logic                mem_we;
    logic [ROW_W-1:0]    waddr;
    logic [ROW_BITS-1:0] wdata;
    logic [ROW_BITS-1:0] req_bit;
    logic [ROW_BITS-1:0] target_bit;
    logic                oor;
    logic                add_new;

    logic [ROW_BITS:0]   mask_incl;
    logic [ROW_BITS:0]   mask_strict;
    logic [ROW_BITS-1:0] row_mask;
    logic [ROW_BITS-1:0] masked;
    logic [BIT_W-1:0]    hi_idx;
    logic [BIT_W-1:0]    lo_idx;
    logic                hit;
    logic [BIT_W-1:0]    hit_bit;
    logic [ROW_W-1:0]    end_row;
    logic [ROW_W-1:0]    issue_end_row;
    logic                at_end;
    logic                scan_done;

    logic [CYL_W-1:0]    l_pos;
    logic                l_down;
    logic                l_incl;

    logic [CYL_W-1:0]    step;
    logic [CYL_W-1:0]    dlo;
    logic [CYL_W-1:0]    dhi;
    logic [SUM_W:0]      sum_ext;
    logic [SEEK_W-1:0]   seek_prod;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_cyl_reg   <= NUM_CYL_RESET;
            seek_rate_reg <= SEEK_RATE_RESET;
        end
        else if (cfg_we)
        begin
            if (cfg_index == CFG_NUM_CYL)
            begin
                num_cyl_reg <= cfg_data;
            end
            else if (cfg_index == CFG_SEEK_RATE)
            begin
                seek_rate_reg <= cfg_data[RATE_W-1:0];
            end
        end
    end

    // item fields
    always_ff @(posedge clk)
    begin
        if (cmd.latch)
        begin
            req_reg  <= request_cylinder;
            hpos_reg <= head_position;
        end
    end

    // bitmap memory, one row read and at most one row written per cycle
    assign raddr   = scan_busy_reg ? scan_addr_reg : req_reg[CYL_W-1:BIT_W];
    assign rd_word = rd_rv_reg ? rd_data_reg : '0;

    assign req_bit    = ROW_BITS'(1) << req_reg[BIT_W-1:0];
    assign target_bit = ROW_BITS'(1) << target_reg[BIT_W-1:0];
    assign oor        = {1'b0, req_reg} >= num_cyl_reg;
    assign add_new    = (rd_word & req_bit) == '0;

    always_comb
    begin
        mem_we = 1'b0;
        waddr  = req_reg[CYL_W-1:BIT_W];
        wdata  = rd_word | req_bit;
        if (cmd.op == DP_ADD)
        begin
            mem_we = !oor;
        end
        else if (cmd.op == DP_COMMIT)
        begin
            mem_we = 1'b1;
            waddr  = target_reg[CYL_W-1:BIT_W];
            wdata  = target_word_reg & ~target_bit;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_data_reg <= mem[raddr];
        rd_rv_reg   <= row_valid_reg[raddr];
        rd_row_reg  <= raddr;
        if (mem_we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // rows never written read as empty
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_valid_reg <= '0;
        end
        else if (mem_we)
        begin
            row_valid_reg[waddr] <= 1'b1;
        end
    end

    // scan launch parameters
    always_comb
    begin
        unique case (cmd.scan_sel)
            SCAN_LO:
            begin
                l_pos  = '0;
                l_down = 1'b0;
                l_incl = 1'b1;
            end
            SCAN_HI:
            begin
                l_pos  = '1;
                l_down = 1'b1;
                l_incl = 1'b1;
            end
            SCAN_MAIN:
            begin
                l_pos  = head_reg;
                l_down = sweep_down_reg;
                l_incl = 1'b1;
            end
            SCAN_REV:
            begin
                l_pos  = head_reg;
                l_down = !sweep_down_reg;
                l_incl = 1'b0;
            end
            default:
            begin
                l_pos  = head_reg;
                l_down = 1'b0;
                l_incl = 1'b0;
            end
        endcase
    end

    // first row masked around the start bit, then nearest set bit
    assign mask_incl   = ((ROW_BITS+1)'(2) << scan_pos_reg[BIT_W-1:0]) - (ROW_BITS+1)'(1);
    assign mask_strict = ((ROW_BITS+1)'(1) << scan_pos_reg[BIT_W-1:0]) - (ROW_BITS+1)'(1);

    always_comb
    begin
        if (rd_row_reg != scan_pos_reg[CYL_W-1:BIT_W])
        begin
            row_mask = '1;
        end
        else if (scan_down_reg)
        begin
            row_mask = scan_incl_reg ? mask_incl[ROW_BITS-1:0] : mask_strict[ROW_BITS-1:0];
        end
        else
        begin
            row_mask = scan_incl_reg ? ~mask_strict[ROW_BITS-1:0] : ~mask_incl[ROW_BITS-1:0];
        end
    end

    assign masked = rd_word & row_mask;
    assign hit    = masked != '0;

    always_comb
    begin
        hi_idx = '0;
        lo_idx = '0;
        for (int i = 0; i < ROW_BITS; i++)
        begin
            if (masked[i])
            begin
                hi_idx = BIT_W'(i);
            end
        end
        for (int i = ROW_BITS - 1; i >= 0; i--)
        begin
            if (masked[i])
            begin
                lo_idx = BIT_W'(i);
            end
        end
    end

    assign hit_bit       = scan_down_reg ? hi_idx : lo_idx;
    assign end_row       = scan_down_reg ? '0 : ROW_W'(ROWS - 1);
    assign at_end        = rd_row_reg == end_row;
    assign issue_end_row = end_row;
    assign scan_done     = scan_busy_reg && scan_vld_reg && (hit || at_end);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scan_busy_reg  <= 1'b0;
            scan_issue_reg <= 1'b0;
            scan_vld_reg   <= 1'b0;
        end
        else if (cmd.scan_start)
        begin
            scan_busy_reg  <= 1'b1;
            scan_issue_reg <= 1'b1;
            scan_vld_reg   <= 1'b0;
        end
        else if (scan_done)
        begin
            scan_busy_reg  <= 1'b0;
            scan_issue_reg <= 1'b0;
            scan_vld_reg   <= 1'b0;
        end
        else
        begin
            scan_vld_reg <= scan_busy_reg && scan_issue_reg;
            if (scan_busy_reg && scan_issue_reg && scan_addr_reg == issue_end_row)
            begin
                scan_issue_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.scan_start)
        begin
            scan_down_reg <= l_down;
            scan_incl_reg <= l_incl;
            scan_pos_reg  <= l_pos;
            scan_addr_reg <= l_pos[CYL_W-1:BIT_W];
        end
        else if (scan_busy_reg && scan_issue_reg && scan_addr_reg != issue_end_row)
        begin
            scan_addr_reg <= scan_down_reg ? scan_addr_reg - ROW_W'(1)
                                           : scan_addr_reg + ROW_W'(1);
        end
        if (scan_done)
        begin
            target_reg      <= {rd_row_reg, hit_bit};
            target_word_reg <= rd_word;
        end
        if (cmd.capture_lo)
        begin
            lo_reg <= target_reg;
        end
    end

    // head movement
    assign step    = (target_reg >= head_reg) ? target_reg - head_reg : head_reg - target_reg;
    assign dlo     = (head_reg >= lo_reg) ? head_reg - lo_reg : lo_reg - head_reg;
    assign dhi     = (target_reg >= head_reg) ? target_reg - head_reg : head_reg - target_reg;
    assign sum_ext = {1'b0, sum_reg} + (SUM_W+1)'(step);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg      <= '0;
            head_reg       <= '0;
            sweep_down_reg <= 1'b0;
            dir_chosen_reg <= 1'b0;
            sum_reg        <= '0;
        end
        else
        begin
            unique case (cmd.op)
                DP_ADD:
                begin
                    if (!oor && add_new)
                    begin
                        count_reg <= count_reg + COUNT_W'(1);
                    end
                end
                DP_START:
                begin
                    head_reg       <= hpos_reg;
                    sum_reg        <= '0;
                    dir_chosen_reg <= 1'b0;
                end
                DP_DIR:
                begin
                    sweep_down_reg <= dlo <= dhi;
                    dir_chosen_reg <= 1'b1;
                end
                DP_FLIP:
                begin
                    sweep_down_reg <= !sweep_down_reg;
                end
                DP_COMMIT:
                begin
                    count_reg <= count_reg - COUNT_W'(1);
                    head_reg  <= target_reg;
                    sum_reg   <= sum_ext[SUM_W] ? SUM_MAX : sum_ext[SUM_W-1:0];
                end
                default:
                begin
                end
            endcase
        end
    end

    // result fields of the current item
    always_ff @(posedge clk)
    begin
        unique case (cmd.op)
            DP_ADD:
            begin
                res_status_reg <= oor ? ST_RANGE : ST_ACCEPTED;
                res_served_reg <= '0;
                res_step_reg   <= '0;
                res_last_reg   <= 1'b0;
                res_serve_reg  <= 1'b0;
            end
            DP_START:
            begin
                res_status_reg <= ST_ACCEPTED;
                res_served_reg <= '0;
                res_step_reg   <= '0;
                res_last_reg   <= 1'b0;
                res_serve_reg  <= 1'b0;
            end
            DP_EMPTY:
            begin
                res_status_reg <= ST_EMPTY;
                res_served_reg <= '0;
                res_step_reg   <= '0;
                res_last_reg   <= 1'b0;
                res_serve_reg  <= 1'b1;
            end
            DP_COMMIT:
            begin
                res_status_reg <= ST_SERVED;
                res_served_reg <= target_reg;
                res_step_reg   <= step;
                res_last_reg   <= count_reg == COUNT_W'(1);
                res_serve_reg  <= 1'b1;
            end
            default:
            begin
            end
        endcase
    end

    // output register
    assign seek_prod = SEEK_W'(sum_reg) * SEEK_W'(seek_rate_reg);

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            out_status_reg <= res_status_reg;
            out_served_reg <= res_served_reg;
            out_step_reg   <= res_step_reg;
            out_last_reg   <= res_last_reg;
            out_total_reg  <= res_serve_reg ? sum_reg : '0;
            out_seek_reg   <= res_serve_reg ? seek_prod : '0;
        end
    end

    assign status          = out_status_reg;
    assign served_cylinder = out_served_reg;
    assign step_movement   = out_step_reg;
    assign total_movement  = out_total_reg;
    assign seek_time       = out_seek_reg;
    assign last            = out_last_reg;

    assign stat.count_zero = count_reg == '0;
    assign stat.dir_chosen = dir_chosen_reg;
    assign stat.scan_done  = scan_done;
    assign stat.scan_found = hit;

endmodule

`default_nettype wire

FILE: rtl/lds_ctrl.sv
// lds_ctrl: sequencer for add, start and serve items and the output handshake
// depends on lds_pkg for states and command and status types
`default_nettype none

module lds_ctrl
    import lds_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    input  wire logic [KIND_W-1:0] in_kind,
    output logic                   in_ready,
    input  wire logic              out_ready,
    output logic                   out_valid,
    input  wire lds_stat_t         stat,
    output lds_cmd_t               cmd
);

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        in_ready       = 1'b0;
        cmd.op         = DP_IDLE;
        cmd.latch      = 1'b0;
        cmd.scan_start = 1'b0;
        cmd.scan_sel   = SCAN_MAIN;
        cmd.capture_lo = 1'b0;
        cmd.out_load   = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.latch = 1'b1;
                    if (in_kind == KIND_ADD)
                    begin
                        state_next = S_ADD_RD;
                    end
                    else if (in_kind == KIND_START)
                    begin
                        state_next = S_START;
                    end
                    else if (in_kind == KIND_SERVE)
                    begin
                        state_next = S_SERVE;
                    end
                end
            end
            S_ADD_RD:
            begin
                state_next = S_ADD_WR;
            end
            S_ADD_WR:
            begin
                cmd.op     = DP_ADD;
                state_next = S_RESULT;
            end
            S_START:
            begin
                cmd.op     = DP_START;
                state_next = S_RESULT;
            end
            S_SERVE:
            begin
                if (stat.count_zero)
                begin
                    cmd.op     = DP_EMPTY;
                    state_next = S_RESULT;
                end
                else if (stat.dir_chosen)
                begin
                    state_next = S_MAIN_GO;
                end
                else
                begin
                    cmd.scan_start = 1'b1;
                    cmd.scan_sel   = SCAN_LO;
                    state_next     = S_LO_WAIT;
                end
            end
            S_LO_WAIT:
            begin
                if (stat.scan_done)
                begin
                    cmd.scan_start = 1'b1;
                    cmd.scan_sel   = SCAN_HI;
                    state_next     = S_HI_WAIT;
                end
            end
            S_HI_WAIT:
            begin
                if (stat.scan_done)
                begin
                    cmd.capture_lo = 1'b1;
                    state_next     = S_DIR;
                end
            end
            S_DIR:
            begin
                cmd.op     = DP_DIR;
                state_next = S_MAIN_GO;
            end
            S_MAIN_GO:
            begin
                cmd.scan_start = 1'b1;
                cmd.scan_sel   = SCAN_MAIN;
                state_next     = S_MAIN_WAIT;
            end
            S_MAIN_WAIT:
            begin
                if (stat.scan_done)
                begin
                    if (stat.scan_found)
                    begin
                        state_next = S_COMMIT;
                    end
                    else
                    begin
                        // end of sweep, turn round
                        cmd.op         = DP_FLIP;
                        cmd.scan_start = 1'b1;
                        cmd.scan_sel   = SCAN_REV;
                        state_next     = S_REV_WAIT;
                    end
                end
            end
            S_REV_WAIT:
            begin
                if (stat.scan_done)
                begin
                    if (stat.scan_found)
                    begin
                        state_next = S_COMMIT;
                    end
                    else
                    begin
                        cmd.op     = DP_EMPTY;
                        state_next = S_RESULT;
                    end
                end
            end
            S_COMMIT:
            begin
                cmd.op     = DP_COMMIT;
                state_next = S_RESULT;
            end
            S_RESULT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

`default_nettype wire

FILE: rtl/look_disk_scheduler_unit.sv
// look_disk_scheduler_unit: top level of the look disk scheduler
// depends on lds_pkg, lds_if, lds_ctrl and lds_datapath
//
// usage
// - in_item carries kind, request_cylinder and head_position; out_item carries one
//   result item per add, start or serve item; kind 3 is dropped with no result
// - cfg_we/cfg_index/cfg_data write num_cylinders (index 0) and seek_rate (index 1);
//   the user must write only while the block is idle, the block does not enforce it
// - one item is processed at a time; in_item.ready is high whenever the sequencer is
//   idle, also while a result waits in the output register
// - an add passes S_ADD_RD, S_ADD_WR and S_RESULT before out_item.valid; a start
//   S_START and S_RESULT; a serve with nothing pending S_SERVE and S_RESULT
// - a serve scans the pending bitmap one 16-cylinder row per cycle through the single
//   read port of the bitmap memory, plus a second scan the other way when the sweep
//   turns round; the first serve after a start adds a scan up from cylinder 0 and
//   one down from the top, each up to 64 rows
// - reset clears the pending set (per-row valid bits, no clearing pass), head,
//   direction, total and the registers to 1024 and 5
// - when out_item.ready is low a finished result waits in the output register; the
//   next item is taken but its result is held until the register is free
`default_nettype none

module look_disk_scheduler_unit
    import lds_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    lds_in_if.sink                     in_item,
    lds_out_if.source                  out_item,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);

    lds_cmd_t  cmd;
    lds_stat_t stat;

    lds_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_item.valid),
        .in_kind   (in_item.kind),
        .in_ready  (in_item.ready),
        .out_ready (out_item.ready),
        .out_valid (out_item.valid),
        .stat      (stat),
        .cmd       (cmd)
    );

    lds_datapath u_datapath (
        .clk              (clk),
        .rst_n            (rst_n),
        .cmd              (cmd),
        .stat             (stat),
        .cfg_we           (cfg_we),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .request_cylinder (in_item.request_cylinder),
        .head_position    (in_item.head_position),
        .status           (out_item.status),
        .served_cylinder  (out_item.served_cylinder),
        .step_movement    (out_item.step_movement),
        .total_movement   (out_item.total_movement),
        .seek_time        (out_item.seek_time),
        .last             (out_item.last)
    );

endmodule

`default_nettype wire
